// ----- rtl/c3s_pkg.sv -----
// Shared widths, payload structs and saturation limits for the 3x3 Cramer solver.
// No dependencies; every other rtl file imports this package.
package c3s_pkg;

    localparam int DW = 32;          // data width of every coefficient and solution field
    localparam int FB = 16;          // fraction bits
    localparam int PW = 2 * DW;      // 2x2 product
    localparam int MW = PW + 1;      // 2x2 minor
    localparam int EW = DW + MW;     // row coefficient times minor
    localparam int SW = EW + 2;      // sum of three expansion terms
    localparam int NL = 3;           // solution lanes

    localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic signed [DW-1:0] a1, b1, c1, d1;
        logic signed [DW-1:0] a2, b2, c2, d2;
        logic signed [DW-1:0] a3, b3, c3, d3;
    } t_coef;

    typedef struct packed {
        logic signed [DW-1:0] a1, b1, c1, d1;
        logic signed [MW-1:0] mbc, mac, mab, mdc, mdb, mad, mbd;
    } t_mnr;

    typedef struct packed {
        logic signed [SW-1:0] det, nx, ny, nz;
    } t_sums;

    typedef struct packed {
        logic [SW-1:0] rem;   // partial remainder, always below the divisor
        logic [DW-1:0] low;   // dividend bits still to shift in, MSB next
        logic [DW-1:0] q;     // quotient magnitude so far
        logic          neg;   // result sign
        logic          ovf;   // quotient known to be at least 2^DW
    } t_lane;

    typedef struct packed {
        t_lane [NL-1:0] lane;
        logic [SW-1:0]  den;
        logic           sing;
    } t_div;

endpackage

// ----- rtl/c3s_minor.sv -----
// Two pipeline stages: fourteen 2x2 products, then the seven 2x2 minors.
// Depends on c3s_pkg.
module c3s_minor import c3s_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_coef i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_mnr  o_data
);

    logic r_v1, r_v2;
    logic w_rdy1, w_rdy2;
    logic signed [DW-1:0] r_a1, r_b1, r_c1, r_d1;
    logic signed [PW-1:0] r_p [14];
    t_mnr r_out;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v2;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_a1    <= i_data.a1;
            r_b1    <= i_data.b1;
            r_c1    <= i_data.c1;
            r_d1    <= i_data.d1;
            r_p[0]  <= i_data.b2 * i_data.c3;
            r_p[1]  <= i_data.b3 * i_data.c2;
            r_p[2]  <= i_data.a2 * i_data.c3;
            r_p[3]  <= i_data.a3 * i_data.c2;
            r_p[4]  <= i_data.a2 * i_data.b3;
            r_p[5]  <= i_data.a3 * i_data.b2;
            r_p[6]  <= i_data.d2 * i_data.c3;
            r_p[7]  <= i_data.d3 * i_data.c2;
            r_p[8]  <= i_data.d2 * i_data.b3;
            r_p[9]  <= i_data.d3 * i_data.b2;
            r_p[10] <= i_data.a2 * i_data.d3;
            r_p[11] <= i_data.a3 * i_data.d2;
            r_p[12] <= i_data.b2 * i_data.d3;
            r_p[13] <= i_data.b3 * i_data.d2;
        end
        if (w_rdy2) begin
            r_out.a1  <= r_a1;
            r_out.b1  <= r_b1;
            r_out.c1  <= r_c1;
            r_out.d1  <= r_d1;
            r_out.mbc <= {r_p[0][PW-1], r_p[0]}   - {r_p[1][PW-1], r_p[1]};
            r_out.mac <= {r_p[2][PW-1], r_p[2]}   - {r_p[3][PW-1], r_p[3]};
            r_out.mab <= {r_p[4][PW-1], r_p[4]}   - {r_p[5][PW-1], r_p[5]};
            r_out.mdc <= {r_p[6][PW-1], r_p[6]}   - {r_p[7][PW-1], r_p[7]};
            r_out.mdb <= {r_p[8][PW-1], r_p[8]}   - {r_p[9][PW-1], r_p[9]};
            r_out.mad <= {r_p[10][PW-1], r_p[10]} - {r_p[11][PW-1], r_p[11]};
            r_out.mbd <= {r_p[12][PW-1], r_p[12]} - {r_p[13][PW-1], r_p[13]};
        end
    end

endmodule

// ----- rtl/c3s_expand.sv -----
// Three pipeline stages: split 32x65 partial products, recombine, sum the
// cofactor expansions of the determinant and the three numerators. Uses c3s_pkg.
module c3s_expand import c3s_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_mnr  i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_sums o_data
);

    // term k: (row coef, minor) for det 0..2, nx 3..5, ny 6..8, nz 9..11
    logic signed [DW-1:0] w_s [12];
    logic signed [MW-1:0] w_m [12];
    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;
    logic signed [DW+DW:0]  r_pl [12];
    logic signed [DW+DW:0]  r_ph [12];
    logic signed [EW-1:0]   r_t  [12];
    logic signed [SW-1:0]   w_sum [4];
    t_sums r_out;

    always_comb begin
        w_s[0]  = i_data.a1; w_m[0]  = i_data.mbc;
        w_s[1]  = i_data.b1; w_m[1]  = i_data.mac;
        w_s[2]  = i_data.c1; w_m[2]  = i_data.mab;
        w_s[3]  = i_data.d1; w_m[3]  = i_data.mbc;
        w_s[4]  = i_data.b1; w_m[4]  = i_data.mdc;
        w_s[5]  = i_data.c1; w_m[5]  = i_data.mdb;
        w_s[6]  = i_data.a1; w_m[6]  = i_data.mdc;
        w_s[7]  = i_data.d1; w_m[7]  = i_data.mac;
        w_s[8]  = i_data.c1; w_m[8]  = i_data.mad;
        w_s[9]  = i_data.a1; w_m[9]  = i_data.mbd;
        w_s[10] = i_data.b1; w_m[10] = i_data.mad;
        w_s[11] = i_data.d1; w_m[11] = i_data.mab;
    end

    // middle term of each expansion is subtracted
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_sum[k] = {{2{r_t[3*k][EW-1]}}, r_t[3*k]}
                     - {{2{r_t[3*k+1][EW-1]}}, r_t[3*k+1]}
                     + {{2{r_t[3*k+2][EW-1]}}, r_t[3*k+2]};
        end
    end

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v3;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 12; k++) begin
            if (w_rdy1) begin
                r_pl[k] <= w_s[k] * $signed({1'b0, w_m[k][DW-1:0]});
                r_ph[k] <= w_s[k] * $signed(w_m[k][MW-1:DW]);
            end
            if (w_rdy2) begin
                r_t[k] <= {{(EW-DW-DW-1){r_pl[k][DW+DW]}}, r_pl[k]}
                        + {r_ph[k], {DW{1'b0}}};
            end
        end
        if (w_rdy3) begin
            r_out.det <= w_sum[0];
            r_out.nx  <= w_sum[1];
            r_out.ny  <= w_sum[2];
            r_out.nz  <= w_sum[3];
        end
    end

endmodule

// ----- rtl/c3s_div_front.sv -----
// Two pipeline stages ahead of the divider: magnitudes and signs, then the
// overflow pre-check and the initial partial remainder. Uses c3s_pkg.
module c3s_div_front import c3s_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_sums i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_div  o_data
);

    logic r_v1, r_v2;
    logic w_rdy1, w_rdy2;
    logic signed [SW-1:0] w_num [NL];
    logic [SW-1:0] r_mag [NL];
    logic          r_nneg [NL];
    logic [SW-1:0] r_dmag;
    logic          r_dneg;
    logic          r_sing;
    logic [SW-1:0] w_hi [NL];
    t_div r_out;

    assign w_num[0] = i_data.nx;
    assign w_num[1] = i_data.ny;
    assign w_num[2] = i_data.nz;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v2;
    assign o_data  = r_out;

    // dividend is mag << FB; its part above the DW quotient bits seeds the remainder
    always_comb begin
        for (int k = 0; k < NL; k++) w_hi[k] = r_mag[k] >> (DW - FB);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            for (int k = 0; k < NL; k++) begin
                r_nneg[k] <= w_num[k][SW-1];
                r_mag[k]  <= w_num[k][SW-1] ? SW'(-w_num[k]) : SW'(w_num[k]);
            end
            r_dneg <= i_data.det[SW-1];
            r_dmag <= i_data.det[SW-1] ? SW'(-i_data.det) : SW'(i_data.det);
            r_sing <= (i_data.det == '0);
        end
        if (w_rdy2) begin
            for (int k = 0; k < NL; k++) begin
                r_out.lane[k].ovf <= (w_hi[k] >= r_dmag);
                r_out.lane[k].rem <= (w_hi[k] >= r_dmag) ? '0 : w_hi[k];
                r_out.lane[k].low <= DW'(r_mag[k] << FB);
                r_out.lane[k].q   <= '0;
                r_out.lane[k].neg <= r_nneg[k] ^ r_dneg;
            end
            r_out.den  <= r_dmag;
            r_out.sing <= r_sing;
        end
    end

endmodule

// ----- rtl/c3s_div_step.sv -----
// One restoring-division stage: one quotient bit for each of the three lanes.
// Uses c3s_pkg; the top level chains DW of these.
module c3s_div_step import c3s_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_div i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_div o_data
);

    logic r_v;
    logic w_rdy;
    logic [SW:0] w_t [NL];
    logic        w_ge [NL];
    t_div w_next;
    t_div r_out;

    always_comb begin
        w_next = i_data;
        for (int k = 0; k < NL; k++) begin
            w_t[k]  = {i_data.lane[k].rem, i_data.lane[k].low[DW-1]};
            w_ge[k] = (w_t[k] >= {1'b0, i_data.den});
            w_next.lane[k].rem = w_ge[k] ? SW'(w_t[k] - {1'b0, i_data.den}) : w_t[k][SW-1:0];
            w_next.lane[k].low = {i_data.lane[k].low[DW-2:0], 1'b0};
            w_next.lane[k].q   = {i_data.lane[k].q[DW-2:0], w_ge[k]};
        end
    end

    assign w_rdy   = !r_v || i_ready;
    assign o_ready = w_rdy;
    assign o_valid = r_v;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy) r_out <= w_next;
    end

endmodule

// ----- rtl/cramer_3x3_linear_solver.sv -----
// Top level of the 3x3 Cramer's-rule solver: minors, expansions, divider chain
// and the saturating output register. Uses c3s_pkg and all c3s_* modules.
//
//  channel  dir  width  contents (lowest bits first)
//  s_axis   in   384    row1 x,y,z,rhs  row2 x,y,z,rhs  row3 x,y,z,rhs
//  m_axis   out  96+2   tdata sol_x,sol_y,sol_z; tuser singular,saturated
//
// One system enters per cycle while m_axis does not stall; each result passes, in
// order, through the minor stages, the expansion stages, the divider setup stages,
// 32 restoring-division stages (one quotient bit each) and the output register.
// Every stage has its own valid bit and advances when empty or when the next
// stage moves, so a stall on m_axis fills the bubbles before s_axis_tready drops.
// Synchronous active-low reset clears all valid bits; no flush cycles follow.
module cramer_3x3_linear_solver import c3s_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [12*DW-1:0]  s_axis_tdata,   // r1x r1y r1z r1d r2x .. r3d
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [NL*DW-1:0]  m_axis_tdata,   // sol_x sol_y sol_z
    output logic [1:0]        m_axis_tuser    // singular saturated
);

    t_coef w_coef;
    t_mnr  w_mnr;
    t_sums w_sums;
    logic  w_mnr_v, w_mnr_r, w_sums_v, w_sums_r;
    logic  w_dv [DW+1];
    logic  w_dr [DW+1];
    t_div  w_dd [DW+1];
    logic  w_out_rdy;
    logic  r_out_v;
    logic [NL*DW-1:0] r_sol;
    logic [1:0]       r_flags;
    logic [DW-1:0]    n_sol [NL];
    logic [NL-1:0]    n_sat;
    t_div  w_fin;

    always_comb begin
        w_coef.a1 = s_axis_tdata[0*DW +: DW];
        w_coef.b1 = s_axis_tdata[1*DW +: DW];
        w_coef.c1 = s_axis_tdata[2*DW +: DW];
        w_coef.d1 = s_axis_tdata[3*DW +: DW];
        w_coef.a2 = s_axis_tdata[4*DW +: DW];
        w_coef.b2 = s_axis_tdata[5*DW +: DW];
        w_coef.c2 = s_axis_tdata[6*DW +: DW];
        w_coef.d2 = s_axis_tdata[7*DW +: DW];
        w_coef.a3 = s_axis_tdata[8*DW +: DW];
        w_coef.b3 = s_axis_tdata[9*DW +: DW];
        w_coef.c3 = s_axis_tdata[10*DW +: DW];
        w_coef.d3 = s_axis_tdata[11*DW +: DW];
    end

    c3s_minor u_minor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (w_coef),
        .o_valid (w_mnr_v),
        .i_ready (w_mnr_r),
        .o_data  (w_mnr)
    );

    c3s_expand u_expand (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mnr_v),
        .o_ready (w_mnr_r),
        .i_data  (w_mnr),
        .o_valid (w_sums_v),
        .i_ready (w_sums_r),
        .o_data  (w_sums)
    );

    c3s_div_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sums_v),
        .o_ready (w_sums_r),
        .i_data  (w_sums),
        .o_valid (w_dv[0]),
        .i_ready (w_dr[0]),
        .o_data  (w_dd[0])
    );

    for (genvar g = 0; g < DW; g++) begin : g_step
        c3s_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_dv[g]),
            .o_ready (w_dr[g]),
            .i_data  (w_dd[g]),
            .o_valid (w_dv[g+1]),
            .i_ready (w_dr[g+1]),
            .o_data  (w_dd[g+1])
        );
    end

    assign w_fin     = w_dd[DW];
    assign w_out_rdy = !r_out_v || m_axis_tready;
    assign w_dr[DW]  = w_out_rdy;

    // zero every solution of a singular system, else sign and clip each quotient magnitude
    always_comb begin
        for (int k = 0; k < NL; k++) begin
            n_sat[k] = 1'b0;
            if (w_fin.sing) begin
                n_sol[k] = '0;
            end else if (w_fin.lane[k].ovf) begin
                n_sol[k] = w_fin.lane[k].neg ? SMIN : SMAX;
                n_sat[k] = 1'b1;
            end else if (w_fin.lane[k].neg) begin
                n_sat[k] = (w_fin.lane[k].q > SMIN);
                n_sol[k] = n_sat[k] ? SMIN : DW'(-w_fin.lane[k].q);
            end else begin
                n_sat[k] = (w_fin.lane[k].q >= SMIN);
                n_sol[k] = n_sat[k] ? SMAX : w_fin.lane[k].q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_rdy) begin
            r_out_v <= w_dv[DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy) begin
            r_sol   <= {n_sol[2], n_sol[1], n_sol[0]};
            r_flags <= {|n_sat, w_fin.sing};
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_sol;
    assign m_axis_tuser  = r_flags;

endmodule

// ----- rtl/c3s_checker.sv -----
// Port-level checks for the Cramer solver, bound to the top level.
// Uses c3s_pkg for widths and saturation limits.
module c3s_checker import c3s_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [NL*DW-1:0]  m_axis_tdata,
    input logic [1:0]        m_axis_tuser
);

    logic w_any_rail;

    assign w_any_rail = (m_axis_tdata[0*DW +: DW] == SMAX) || (m_axis_tdata[0*DW +: DW] == SMIN)
                     || (m_axis_tdata[1*DW +: DW] == SMAX) || (m_axis_tdata[1*DW +: DW] == SMIN)
                     || (m_axis_tdata[2*DW +: DW] == SMAX) || (m_axis_tdata[2*DW +: DW] == SMIN);

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_singular: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
        else $error("singular result not zero");

    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> w_any_rail)
        else $error("saturated flag without a clipped solution");

endmodule

bind cramer_3x3_linear_solver c3s_checker u_c3s_checker (.*);
